FILE: rtl/core/blsf_pkg.sv
// Shared types and constants for the battery level and power status filter.
`default_nettype none

package blsf_pkg;

  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgCount     = 8;

  localparam logic [2:0] REG_VBUS_THR     = 3'd0;
  localparam logic [2:0] REG_BAND_TWO     = 3'd1;
  localparam logic [2:0] REG_BAND_THREE   = 3'd2;
  localparam logic [2:0] REG_BAND_FOUR    = 3'd3;
  localparam logic [2:0] REG_BAND_HYST    = 3'd4;
  localparam logic [2:0] REG_BAND_CONFIRM = 3'd5;
  localparam logic [2:0] REG_CHARGE_ENTER = 3'd6;
  localparam logic [2:0] REG_CHARGE_EXIT  = 3'd7;

  localparam logic [14:0] VBUS_THR_RESET     = 15'd4000;
  localparam logic [6:0]  BAND_TWO_RESET     = 7'd25;
  localparam logic [6:0]  BAND_THREE_RESET   = 7'd50;
  localparam logic [6:0]  BAND_FOUR_RESET    = 7'd75;
  localparam logic [4:0]  BAND_HYST_RESET    = 5'd3;
  localparam logic [3:0]  BAND_CONFIRM_RESET = 4'd3;
  localparam logic [3:0]  CHARGE_ENTER_RESET = 4'd2;
  localparam logic [3:0]  CHARGE_EXIT_RESET  = 4'd3;

  localparam logic [6:0] FULL_PERCENT = 7'd100;

  localparam logic [2:0] BAND_UNSET = 3'd0;
  localparam logic [2:0] BAND_ONE   = 3'd1;
  localparam logic [2:0] BAND_TWO   = 3'd2;
  localparam logic [2:0] BAND_THREE = 3'd3;
  localparam logic [2:0] BAND_FOUR  = 3'd4;

  localparam logic [1:0] STATUS_BATTERY  = 2'd0;
  localparam logic [1:0] STATUS_CHARGING = 2'd1;
  localparam logic [1:0] STATUS_USB      = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic [14:0] vbus_thr;
    logic [6:0]  band_two;
    logic [6:0]  band_three;
    logic [6:0]  band_four;
    logic [4:0]  band_hyst;
    logic [3:0]  band_confirm;
    logic [3:0]  charge_enter;
    logic [3:0]  charge_exit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/blsf_regs.sv
// APB configuration register file for the battery level filter.
`default_nettype none

module blsf_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [blsf_pkg::CfgAddrWidth-1:0]  paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  output blsf_pkg::cfg_t                          cfg
);
  import blsf_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vbus_thr     <= VBUS_THR_RESET;
      cfg.band_two     <= BAND_TWO_RESET;
      cfg.band_three   <= BAND_THREE_RESET;
      cfg.band_four    <= BAND_FOUR_RESET;
      cfg.band_hyst    <= BAND_HYST_RESET;
      cfg.band_confirm <= BAND_CONFIRM_RESET;
      cfg.charge_enter <= CHARGE_ENTER_RESET;
      cfg.charge_exit  <= CHARGE_EXIT_RESET;
    end else if (wr) begin
      case (idx)
        REG_VBUS_THR:     cfg.vbus_thr     <= pwdata[14:0];
        REG_BAND_TWO:     cfg.band_two     <= pwdata[6:0];
        REG_BAND_THREE:   cfg.band_three   <= pwdata[6:0];
        REG_BAND_FOUR:    cfg.band_four    <= pwdata[6:0];
        REG_BAND_HYST:    cfg.band_hyst    <= pwdata[4:0];
        REG_BAND_CONFIRM: cfg.band_confirm <= pwdata[3:0];
        REG_CHARGE_ENTER: cfg.charge_enter <= pwdata[3:0];
        REG_CHARGE_EXIT:  cfg.charge_exit  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VBUS_THR:     prdata = {17'd0, cfg.vbus_thr};
      REG_BAND_TWO:     prdata = {25'd0, cfg.band_two};
      REG_BAND_THREE:   prdata = {25'd0, cfg.band_three};
      REG_BAND_FOUR:    prdata = {25'd0, cfg.band_four};
      REG_BAND_HYST:    prdata = {27'd0, cfg.band_hyst};
      REG_BAND_CONFIRM: prdata = {28'd0, cfg.band_confirm};
      REG_CHARGE_ENTER: prdata = {28'd0, cfg.charge_enter};
      REG_CHARGE_EXIT:  prdata = {28'd0, cfg.charge_exit};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/blsf_rank.sv
// Rank unit that tests whether one ring entry is the upper median of the held entries.
`default_nettype none

module blsf_rank #(
  parameter int unsigned N  = 5,
  parameter int unsigned PW = 3,
  parameter int unsigned FW = 3
) (
  input  wire logic [N-1:0][6:0] ring,
  input  wire logic [FW-1:0]     fill,
  input  wire logic [PW-1:0]     idx,
  output logic                   hit
);

  logic [6:0]    cand;
  logic [N-1:0]  below;
  logic [FW-1:0] rank;
  logic [FW-1:0] target;

  assign cand   = ring[idx];
  assign target = fill >> 1;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      below[j] = (FW'(j) < fill) &&
                 ((ring[j] < cand) || ((ring[j] == cand) && (PW'(j) < idx)));
    end
  end

  assign rank = FW'($countones(below));
  assign hit  = (rank == target);

endmodule

`default_nettype wire

FILE: rtl/core/battery_level_status_filter_core.sv
// Top level of the battery level and power status filter with its step sequencer.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready| raw battery percent, charge_pin, vbus_millivolts
//  m_axis   | m_axis_tvalid/m_axis_tready| available, shown_percent, level_band, status
//  apb      | psel/penable/pwrite/pready | eight configuration registers
//
// A poll updates all filter state when it is accepted, then the rank unit tests one ring
// entry per cycle until it finds the median (the upper one for an even count), and the
// output register is loaded once it is free.
// The block accepts a new poll only when idle; the output register holds one result,
// so a stalled output lets one more poll in and blocks the input once that poll's
// result is finished.
// Reset is synchronous and clears all control state; ring contents are not cleared.
`default_nettype none

module battery_level_status_filter_core #(
  parameter int unsigned MEDIAN_WINDOW       = 5,
  parameter int unsigned UNREADABLE_HOLDOVER = 3,
  parameter int unsigned FULL_CONFIRM        = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [8:0] raw battery percent, [9] charge_pin, [25:10] vbus_millivolts, [31:26] zero
  input  wire logic [31:0]                       s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] available, [7:1] shown_percent, [10:8] level_band, [12:11] power_status,
  // [15:13] zero
  output logic [15:0]                            m_axis_tdata,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [blsf_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import blsf_pkg::*;

  localparam int unsigned N  = MEDIAN_WINDOW;
  localparam int unsigned PW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned FW = $clog2(N + 1);
  localparam int unsigned SW = $clog2(UNREADABLE_HOLDOVER + 2);
  localparam int unsigned CW = $clog2(FULL_CONFIRM + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_DONE
  } state_t;

  cfg_t cfg;

  blsf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t              state;
  logic [N-1:0][6:0]   ring;
  logic [PW-1:0]       wpos;
  logic [FW-1:0]       fill;
  logic [SW-1:0]       streak;
  logic [3:0]          on_cnt;
  logic [3:0]          off_cnt;
  logic                disp;
  logic [CW-1:0]       full_cnt;
  logic [2:0]          cband;
  logic [2:0]          pband;
  logic [3:0]          pcnt;
  logic [1:0]          last_status;
  logic                avail;
  logic [6:0]          median;
  logic [PW-1:0]       idx;
  logic                hit;

  logic                out_valid;
  logic [15:0]         out_data;

  logic [8:0]          level;
  logic                pin;
  logic [15:0]         vbus;
  logic                accept;
  logic                vbus_ok;
  logic                vbus_high;
  logic                unplug;
  logic                readable;
  logic [6:0]          sample;
  logic                external;

  logic [PW-1:0]       wpos_next;
  logic [FW-1:0]       fill_next;
  logic [SW-1:0]       streak_next;
  logic [3:0]          on_cnt_next;
  logic [3:0]          off_cnt_next;
  logic                disp_next;
  logic [CW-1:0]       full_cnt_next;
  logic [2:0]          cband_next;
  logic [2:0]          pband_next;
  logic [3:0]          pcnt_next;
  logic [4:0]          pcnt_inc;
  logic [1:0]          status_next;
  logic [2:0]          want;
  logic signed [8:0]   p_s;
  logic signed [8:0]   four_keep;
  logic signed [8:0]   three_keep;
  logic signed [8:0]   two_keep;

  assign level  = s_axis_tdata[8:0];
  assign pin    = s_axis_tdata[9];
  assign vbus   = s_axis_tdata[25:10];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  assign vbus_ok   = !vbus[15] && (vbus != 16'd0);
  assign vbus_high = vbus_ok && (vbus[14:0] > cfg.vbus_thr);
  assign unplug    = vbus_ok && !vbus_high;
  assign readable  = !level[8];
  assign sample    = (level[7:0] > 8'(FULL_PERCENT)) ? FULL_PERCENT : level[6:0];

  assign p_s        = {2'b00, sample};
  assign four_keep  = $signed({2'b00, cfg.band_four})  - $signed({4'b0000, cfg.band_hyst});
  assign three_keep = $signed({2'b00, cfg.band_three}) - $signed({4'b0000, cfg.band_hyst});
  assign two_keep   = $signed({2'b00, cfg.band_two})   - $signed({4'b0000, cfg.band_hyst});

  always_comb begin
    if (sample >= cfg.band_four) begin
      want = BAND_FOUR;
    end else if ((cband == BAND_FOUR) && (p_s >= four_keep)) begin
      want = BAND_FOUR;
    end else if (sample >= cfg.band_three) begin
      want = BAND_THREE;
    end else if (((cband == BAND_FOUR) || (cband == BAND_THREE)) && (p_s >= three_keep)) begin
      want = BAND_THREE;
    end else if (sample >= cfg.band_two) begin
      want = BAND_TWO;
    end else if ((cband >= BAND_TWO) && (cband <= BAND_FOUR) && (p_s >= two_keep)) begin
      want = BAND_TWO;
    end else begin
      want = BAND_ONE;
    end
  end

  always_comb begin
    wpos_next   = wpos;
    fill_next   = fill;
    streak_next = streak;
    cband_next  = cband;
    pband_next  = pband;
    pcnt_next   = pcnt;
    pcnt_inc    = 5'd0;

    if (!readable) begin
      if (streak <= SW'(UNREADABLE_HOLDOVER)) begin
        streak_next = streak + 1'b1;
      end
      if (streak_next > SW'(UNREADABLE_HOLDOVER)) begin
        fill_next  = '0;
        wpos_next  = '0;
        cband_next = BAND_UNSET;
        pband_next = BAND_UNSET;
        pcnt_next  = 4'd0;
      end
    end else begin
      streak_next = '0;
      wpos_next   = (wpos == PW'(N - 1)) ? '0 : wpos + 1'b1;
      if (fill < FW'(N)) begin
        fill_next = fill + 1'b1;
      end
      if ((cband == BAND_UNSET) || (cband == want)) begin
        pband_next = want;
        pcnt_next  = 4'd0;
        cband_next = want;
      end else begin
        pcnt_inc = (pband != want) ? 5'd1 : {1'b0, pcnt} + 5'd1;
        pband_next = want;
        if (pcnt_inc >= {1'b0, cfg.band_confirm}) begin
          pcnt_next  = 4'd0;
          cband_next = want;
        end else begin
          pcnt_next = pcnt_inc[3:0];
        end
      end
    end
  end

  always_comb begin
    on_cnt_next   = on_cnt;
    off_cnt_next  = off_cnt;
    disp_next     = disp;
    full_cnt_next = full_cnt;
    if (unplug) begin
      on_cnt_next   = 4'd0;
      off_cnt_next  = 4'd0;
      disp_next     = 1'b0;
      full_cnt_next = '0;
    end else begin
      if (pin) begin
        off_cnt_next = 4'd0;
        if (on_cnt < cfg.charge_enter) begin
          on_cnt_next = on_cnt + 1'b1;
        end
      end else begin
        on_cnt_next = 4'd0;
        if (off_cnt < cfg.charge_exit) begin
          off_cnt_next = off_cnt + 1'b1;
        end
      end
      if (!disp && (on_cnt_next >= cfg.charge_enter)) begin
        disp_next = 1'b1;
      end else if (disp && (off_cnt_next >= cfg.charge_exit)) begin
        disp_next = 1'b0;
      end
    end

    external    = vbus_high || (!vbus_ok && disp_next);
    status_next = last_status;
    if (!external) begin
      status_next = STATUS_BATTERY;
    end else if (disp_next) begin
      status_next   = STATUS_CHARGING;
      full_cnt_next = '0;
    end else if (!readable) begin
      full_cnt_next = '0;
      if (last_status != STATUS_FULL) begin
        status_next = STATUS_USB;
      end
    end else if (sample >= FULL_PERCENT) begin
      if (full_cnt_next < CW'(FULL_CONFIRM)) begin
        full_cnt_next = full_cnt_next + 1'b1;
      end
      if (full_cnt_next >= CW'(FULL_CONFIRM)) begin
        status_next = STATUS_FULL;
      end else if ((last_status != STATUS_CHARGING) && (last_status != STATUS_FULL)) begin
        status_next = STATUS_USB;
      end
    end else begin
      full_cnt_next = '0;
      status_next   = STATUS_USB;
    end
  end

  blsf_rank #(
    .N  (N),
    .PW (PW),
    .FW (FW)
  ) u_rank (
    .ring (ring),
    .fill (fill),
    .idx  (idx),
    .hit  (hit)
  );

  always_ff @(posedge clk) begin
    if (accept && readable) begin
      ring[wpos] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wpos        <= '0;
      fill        <= '0;
      streak      <= '0;
      on_cnt      <= 4'd0;
      off_cnt     <= 4'd0;
      disp        <= 1'b0;
      full_cnt    <= '0;
      cband       <= BAND_UNSET;
      pband       <= BAND_UNSET;
      pcnt        <= 4'd0;
      last_status <= STATUS_BATTERY;
      out_valid   <= 1'b0;
      idx         <= '0;
    end else begin
      if (out_valid && m_axis_tready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            wpos        <= wpos_next;
            fill        <= fill_next;
            streak      <= streak_next;
            on_cnt      <= on_cnt_next;
            off_cnt     <= off_cnt_next;
            disp        <= disp_next;
            full_cnt    <= full_cnt_next;
            cband       <= cband_next;
            pband       <= pband_next;
            pcnt        <= pcnt_next;
            last_status <= status_next;
            avail       <= external || (fill_next != '0);
            idx         <= '0;
            state       <= ST_RANK;
          end
        end
        ST_RANK: begin
          if (fill == '0) begin
            median <= 7'd0;
            state  <= ST_DONE;
          end else if (hit || (FW'(idx) == fill - 1'b1)) begin
            median <= ring[idx];
            state  <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_data  <= {3'd0, last_status, cband, median, avail};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

FILE: tb/tb_battery_level_status_filter_core.sv
// Self-checking testbench for the battery level and power status filter core.
`default_nettype none

module tb_battery_level_status_filter_core;
  import blsf_pkg::*;

  localparam int WINDOW   = 5;
  localparam int HOLDOVER = 3;
  localparam int FULL_RUN = 3;

  typedef struct packed {
    logic signed [15:0] vbus;
    logic               pin;
    logic signed [8:0]  level;
  } poll_t;

  typedef struct packed {
    logic [1:0] power_status;
    logic [2:0] level_band;
    logic [6:0] shown_percent;
    logic       available;
  } status_word_t;

  typedef struct packed {
    logic signed [8:0]  level;
    logic               pin;
    logic signed [15:0] vbus;
    logic               known;
    logic               available;
    logic [6:0]         shown_percent;
    logic [2:0]         level_band;
    logic [1:0]         power_status;
  } poll_row_t;

  localparam poll_row_t DIRECTED [25] = '{
    '{  -1, 0,      0, 1, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{ 100, 0,   5000, 1, 1, 100, BAND_FOUR,  STATUS_USB},
    '{ 255, 0,  32767, 1, 1, 100, BAND_FOUR,  STATUS_USB},
    '{ 101, 0,   5000, 1, 1, 100, BAND_FOUR,  STATUS_FULL},
    '{-256, 0,   5000, 1, 1, 100, BAND_FOUR,  STATUS_FULL},
    '{   0, 0,      1, 1, 1, 100, BAND_FOUR,  STATUS_BATTERY},
    '{   0, 0, -32768, 1, 1, 100, BAND_FOUR,  STATUS_BATTERY},
    '{   0, 0,      0, 1, 1,   0, BAND_ONE,   STATUS_BATTERY},
    '{  -1, 0,      0, 1, 1,   0, BAND_ONE,   STATUS_BATTERY},
    '{  -1, 0,      0, 1, 1,   0, BAND_ONE,   STATUS_BATTERY},
    '{  -1, 0,      0, 1, 1,   0, BAND_ONE,   STATUS_BATTERY},
    '{  -1, 0,      0, 1, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{  -1, 0,      0, 1, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{  50, 1,      0, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{  50, 1,      0, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{  99, 1,   5000, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{ 100, 0,   5000, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{ 100, 0,   5000, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{ 100, 0,   5000, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{ 100, 0,   5000, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{ 100, 0,   5000, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{  73, 0,   5000, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{  71, 0,   4001, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{  49, 1,   4000, 0, 0,   0, BAND_UNSET, STATUS_BATTERY},
    '{  24, 0,     -1, 0, 0,   0, BAND_UNSET, STATUS_BATTERY}
  };

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [31:0]             s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [15:0]             m_axis_tdata;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  battery_level_status_filter_core #(
    .MEDIAN_WINDOW      (WINDOW),
    .UNREADABLE_HOLDOVER(HOLDOVER),
    .FULL_CONFIRM       (FULL_RUN)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  cfg_t         cfg;
  logic [6:0]   level_hist [WINDOW];
  int           hist_wr, hist_cnt, bad_run, on_run, off_run, full_run, band_cand_run;
  bit           icon_on;
  logic [2:0]   band_now, band_cand;
  logic [1:0]   prev_status;

  status_word_t status_due [$];
  int           polls_sent, results_seen, mismatches, settings_used;
  int           src_idle_pct, sink_idle_pct;

  int           walk_level, vbus_kind, bad_burst;
  bit           pin_now;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void reset_filter();
    cfg = '{VBUS_THR_RESET, BAND_TWO_RESET, BAND_THREE_RESET, BAND_FOUR_RESET,
            BAND_HYST_RESET, BAND_CONFIRM_RESET, CHARGE_ENTER_RESET, CHARGE_EXIT_RESET};
    hist_wr = 0;
    hist_cnt = 0;
    bad_run = 0;
    on_run = 0;
    off_run = 0;
    full_run = 0;
    band_cand_run = 0;
    icon_on = 1'b0;
    band_now = BAND_UNSET;
    band_cand = BAND_UNSET;
    prev_status = STATUS_BATTERY;
  endfunction

  function automatic status_word_t filter_poll(input poll_t p);
    int           lvl, mv, hyst, n, j;
    bit           mv_ok, powered, unplugged, ok, ext;
    logic [6:0]   smp, k;
    logic [6:0]   srt [WINDOW];
    logic [2:0]   want;
    logic [1:0]   st;
    status_word_t r;
    lvl = $signed(p.level);
    mv = $signed(p.vbus);
    mv_ok = mv > 0;
    powered = mv_ok && mv > int'(cfg.vbus_thr);
    unplugged = mv_ok && !powered;
    ok = lvl >= 0;
    smp = !ok ? 7'd0 : (lvl > 100 ? FULL_PERCENT : 7'(lvl));

    if (!ok) begin
      if (bad_run <= HOLDOVER) bad_run++;
      if (bad_run > HOLDOVER) begin
        hist_cnt = 0;
        hist_wr = 0;
        band_now = BAND_UNSET;
        band_cand = BAND_UNSET;
        band_cand_run = 0;
      end
    end else begin
      level_hist[hist_wr] = smp;
      hist_wr = (hist_wr + 1) % WINDOW;
      if (hist_cnt < WINDOW) hist_cnt++;
      bad_run = 0;
    end

    if (unplugged) begin
      on_run = 0;
      off_run = 0;
      icon_on = 1'b0;
      full_run = 0;
    end else begin
      if (p.pin) begin
        off_run = 0;
        if (on_run < int'(cfg.charge_enter)) on_run++;
      end else begin
        on_run = 0;
        if (off_run < int'(cfg.charge_exit)) off_run++;
      end
      if (!icon_on && on_run >= int'(cfg.charge_enter)) icon_on = 1'b1;
      else if (icon_on && off_run >= int'(cfg.charge_exit)) icon_on = 1'b0;
    end

    ext = powered || (!mv_ok && icon_on);

    if (ok) begin
      hyst = int'(cfg.band_hyst);
      if (int'(smp) >= int'(cfg.band_four)) want = BAND_FOUR;
      else if (band_now == BAND_FOUR && int'(smp) >= int'(cfg.band_four) - hyst)
        want = BAND_FOUR;
      else if (int'(smp) >= int'(cfg.band_three)) want = BAND_THREE;
      else if ((band_now == BAND_FOUR || band_now == BAND_THREE) &&
               int'(smp) >= int'(cfg.band_three) - hyst)
        want = BAND_THREE;
      else if (int'(smp) >= int'(cfg.band_two)) want = BAND_TWO;
      else if (band_now >= BAND_TWO && band_now <= BAND_FOUR &&
               int'(smp) >= int'(cfg.band_two) - hyst)
        want = BAND_TWO;
      else want = BAND_ONE;

      if (band_now == BAND_UNSET || band_now == want) begin
        band_cand = want;
        band_cand_run = 0;
        band_now = want;
      end else begin
        if (band_cand != want) begin
          band_cand = want;
          band_cand_run = 0;
        end
        band_cand_run++;
        if (band_cand_run >= int'(cfg.band_confirm)) begin
          band_cand_run = 0;
          band_now = want;
        end
      end
    end

    st = prev_status;
    if (!ext) begin
      st = STATUS_BATTERY;
    end else if (icon_on) begin
      st = STATUS_CHARGING;
      full_run = 0;
    end else if (!ok) begin
      full_run = 0;
      if (st != STATUS_FULL) st = STATUS_USB;
    end else if (smp >= FULL_PERCENT) begin
      if (full_run < FULL_RUN) full_run++;
      if (full_run >= FULL_RUN) st = STATUS_FULL;
      else if (st != STATUS_CHARGING && st != STATUS_FULL) st = STATUS_USB;
    end else begin
      full_run = 0;
      st = STATUS_USB;
    end
    prev_status = st;

    r.available = ext || hist_cnt > 0;
    r.shown_percent = 7'd0;
    if (hist_cnt > 0) begin
      n = hist_cnt;
      for (int i = 0; i < n; i++) srt[i] = level_hist[i];
      for (int i = 1; i < n; i++) begin
        k = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > k) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = k;
      end
      r.shown_percent = srt[n/2];
    end
    r.level_band = band_now;
    r.power_status = st;
    return r;
  endfunction

  function automatic logic [31:0] cfg_value(input logic [2:0] idx);
    case (idx)
      REG_VBUS_THR:     return 32'(cfg.vbus_thr);
      REG_BAND_TWO:     return 32'(cfg.band_two);
      REG_BAND_THREE:   return 32'(cfg.band_three);
      REG_BAND_FOUR:    return 32'(cfg.band_four);
      REG_BAND_HYST:    return 32'(cfg.band_hyst);
      REG_BAND_CONFIRM: return 32'(cfg.band_confirm);
      REG_CHARGE_ENTER: return 32'(cfg.charge_enter);
      default:          return 32'(cfg.charge_exit);
    endcase
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  task automatic cfg_access(input logic [2:0] idx, input bit wr, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CfgAddrWidth'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== cfg_value(idx))
      note_mismatch($sformatf("register %0d read expected %0d, got %0d",
                              idx, cfg_value(idx), prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_access(idx, 1'b1, val);
    case (idx)
      REG_VBUS_THR:     cfg.vbus_thr = val[14:0];
      REG_BAND_TWO:     cfg.band_two = val[6:0];
      REG_BAND_THREE:   cfg.band_three = val[6:0];
      REG_BAND_FOUR:    cfg.band_four = val[6:0];
      REG_BAND_HYST:    cfg.band_hyst = val[4:0];
      REG_BAND_CONFIRM: cfg.band_confirm = val[3:0];
      REG_CHARGE_ENTER: cfg.charge_enter = val[3:0];
      default:          cfg.charge_exit = val[3:0];
    endcase
    cfg_access(idx, 1'b0, '0);
  endtask

  task automatic apply_settings(input int thr, input int two, input int three, input int four,
                                input int hyst, input int confirm, input int enter,
                                input int leave);
    cfg_write(REG_VBUS_THR, thr);
    cfg_write(REG_BAND_TWO, two);
    cfg_write(REG_BAND_THREE, three);
    cfg_write(REG_BAND_FOUR, four);
    cfg_write(REG_BAND_HYST, hyst);
    cfg_write(REG_BAND_CONFIRM, confirm);
    cfg_write(REG_CHARGE_ENTER, enter);
    cfg_write(REG_CHARGE_EXIT, leave);
    settings_used++;
  endtask

  task automatic send_poll(input poll_t p, input bit known, input status_word_t typed);
    status_word_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, p};
    do @(posedge clk); while (!s_axis_tready);
    r = filter_poll(p);
    status_due.push_back(known ? typed : r);
    polls_sent++;
  endtask

  // Mostly a slowly drifting level with sticky charger and supply conditions,
  // interleaved with bursts of failed reads and fully random raw values.
  function automatic poll_t next_poll();
    poll_t p;
    int    thr, mv;
    thr = int'(cfg.vbus_thr);
    if ($urandom_range(99) < 8) pin_now = ~pin_now;
    if ($urandom_range(99) < 6) vbus_kind = $urandom_range(2);
    if (bad_burst == 0 && $urandom_range(99) < 4) bad_burst = $urandom_range(1, 6);
    walk_level += $urandom_range(6) - 3;
    if ($urandom_range(99) < 3) walk_level = $urandom_range(110);
    if (walk_level < 0) walk_level = 0;
    if (walk_level > 110) walk_level = 110;

    if (bad_burst > 0) begin
      p.level = -9'sd1 - 9'($urandom_range(255));
      bad_burst--;
    end else if ($urandom_range(99) < 8) begin
      p.level = 9'($urandom);
    end else begin
      p.level = 9'(walk_level);
    end

    case (vbus_kind)
      0: mv = $urandom_range(1) ? 0 : -int'($urandom_range(1, 32768));
      1: mv = thr >= 1 ? int'($urandom_range(1, thr)) : 0;
      default: mv = thr < 32767 ? int'($urandom_range(thr + 1, 32767)) : 32767;
    endcase
    if ($urandom_range(99) < 5) mv = $urandom;
    p.vbus = 16'(mv);
    p.pin = ($urandom_range(99) < 5) ? 1'($urandom) : pin_now;
    return p;
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_poll(next_poll(), 1'b0, '0);
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    for (int w = 0; w < 20000 && status_due.size() > 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic check_result(input status_word_t got);
    status_word_t want;
    results_seen++;
    if (status_due.size() == 0) begin
      note_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
    end else begin
      want = status_due.pop_front();
      if (got.available !== want.available || got.shown_percent !== want.shown_percent ||
          got.level_band !== want.level_band || got.power_status !== want.power_status)
        note_mismatch($sformatf(
          "result %0d expected avail %0d pct %0d band %0d status %0d, got %0d %0d %0d %0d",
          results_seen, want.available, want.shown_percent, want.level_band,
          want.power_status, got.available, got.shown_percent, got.level_band,
          got.power_status));
    end
  endtask

  // Output side: random back-pressure plus one long hold-off that fills the block.
  initial begin
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata[12:0]);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (!held_once && results_seen >= 300) begin
        held_once = 1'b1;
        hold_left = 400;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    int lo, mid, hi, t;
    polls_sent = 0;
    results_seen = 0;
    mismatches = 0;
    settings_used = 1;
    walk_level = 50;
    vbus_kind = 2;
    bad_burst = 0;
    pin_now = 1'b0;
    src_idle_pct = 29;
    sink_idle_pct = 61;
    reset_filter();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_poll('{DIRECTED[i].vbus, DIRECTED[i].pin, DIRECTED[i].level}, DIRECTED[i].known,
                '{DIRECTED[i].power_status, DIRECTED[i].level_band,
                  DIRECTED[i].shown_percent, DIRECTED[i].available});
    send_random(150);
    finish_phase();

    for (int ph = 1; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          src_idle_pct = 29;
          sink_idle_pct = 61;
        end
        1: begin
          src_idle_pct = 61;
          sink_idle_pct = 29;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      case (ph)
        1: apply_settings(0, 0, 0, 0, 0, 1, 1, 1);
        2: apply_settings(32767, 100, 100, 100, 20, 15, 15, 15);
        3: apply_settings(3000, 2, 10, 15, 20, 0, 0, 0);
        4: begin
          lo = $urandom_range(100);
          mid = $urandom_range(100);
          hi = $urandom_range(100);
          if (lo > mid) begin t = lo; lo = mid; mid = t; end
          if (mid > hi) begin t = mid; mid = hi; hi = t; end
          if (lo > mid) begin t = lo; lo = mid; mid = t; end
          apply_settings($urandom_range(8000), lo, mid, hi, $urandom_range(20),
                         $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6));
        end
        default: apply_settings(int'(VBUS_THR_RESET), int'(BAND_TWO_RESET),
                                int'(BAND_THREE_RESET), int'(BAND_FOUR_RESET),
                                int'(BAND_HYST_RESET), int'(BAND_CONFIRM_RESET),
                                int'(CHARGE_ENTER_RESET), int'(CHARGE_EXIT_RESET));
      endcase
      send_random(150);
      finish_phase();
    end

    if (status_due.size() > 0)
      note_mismatch($sformatf("%0d results never arrived", status_due.size()));
    $display("Run covered %0d polls under %0d register settings, checked %0d results.",
             polls_sent, settings_used, results_seen);
    $display("Mismatches counted: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/blsf_pkg.sv
rtl/core/blsf_regs.sv
rtl/core/blsf_rank.sv
rtl/core/battery_level_status_filter_core.sv
tb/tb_battery_level_status_filter_core.sv
